// ===== design/kcg_pkg.sv =====
// kcg_pkg: shared types and constants for the keyframe color gradient core.
// Holds the sequencer state type and the register map; no dependencies.
`timescale 1ns / 1ps

package kcg_pkg;

  // Register map, indexed by paddr[4:2]
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] RegNumColors = 3'd0;
  localparam logic [RegIdxW-1:0] RegAnimLength = 3'd1;
  localparam logic [RegIdxW-1:0] RegKeyColor0 = 3'd2;
  localparam logic [RegIdxW-1:0] RegKeyColor1 = 3'd3;
  localparam logic [RegIdxW-1:0] RegKeyColor2 = 3'd4;
  localparam logic [RegIdxW-1:0] RegKeyColor3 = 3'd5;
  localparam logic [RegIdxW-1:0] RegIdleColor = 3'd6;

  // Keyframes that have a register behind them
  localparam int unsigned KeyRegs = 4;

  localparam int unsigned ColorW = 32;
  localparam int unsigned ChanW = 8;
  localparam int unsigned LenW = 16;
  localparam int unsigned FracW = 16;
  localparam int unsigned NumColorsW = 3;

  // Reset values of the configuration registers
  localparam logic [NumColorsW-1:0] NumColorsRst = 3'd2;
  localparam logic [LenW-1:0] AnimLengthRst = 16'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LDSRC,
    ST_LDDST,
    ST_BLEND,
    ST_DONE
  } kcg_state_e;

endpackage

// ===== design/keyframe_color_gradient_core.sv =====
// keyframe_color_gradient_core: animated multi-stop RGBA gradient, one color per tick.
// Uses kcg_pkg for the register map, widths and sequencer states.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                  | Contents
// ---------+-----+----------------------------+------------------------------------
// s_axis   | in  | s_axis_tvalid/s_axis_tready| tdata[0] enable, [7:1] zero
// m_axis   | out | m_axis_tvalid/m_axis_tready| tdata red[7:0] green[15:8]
//          |     |                            |   blue[23:16] alpha[31:24]
// apb      | in  | psel/penable/pwrite/pready | registers at 4*index, pready always high
//
// An enabled tick goes through the multiply, the bit-serial restoring divide, the
// segment start and end loads and the blend of each channel before its result is
// registered; the divider dominates. A disabled tick goes straight to the result
// step. One item is in work at a time; s_axis_tready is high only while the
// sequencer is idle. The result register lets a new item be taken while the
// previous result still waits; a finished item that meets a waiting result holds in
// its last step. Reset clears the frame counter and loads the register defaults.

module keyframe_color_gradient_core #(
  parameter int unsigned MAX_COLORS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] enable, [7:1] zero fill
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SegW = $clog2(MAX_COLORS);
  localparam int unsigned ProdW = kcg_pkg::LenW + SegW;
  localparam int unsigned NumW = ProdW + kcg_pkg::FracW;
  localparam int unsigned CntW = $clog2(NumW);
  localparam int unsigned ChW = kcg_pkg::ChanW;
  localparam int unsigned BlendW = ChW + kcg_pkg::FracW + 2;

  // ---------------------------------------------------------------- config
  logic [kcg_pkg::NumColorsW-1:0] num_colors_q;
  logic [kcg_pkg::LenW-1:0]       anim_length_q;
  logic [kcg_pkg::ColorW-1:0]     key_reg_q [kcg_pkg::KeyRegs];
  logic [kcg_pkg::ColorW-1:0]     idle_color_q;
  logic [kcg_pkg::RegIdxW-1:0]    reg_idx;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  // Write registers; keyframes beyond MAX_COLORS drop their writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_colors_q  <= kcg_pkg::NumColorsRst;
      anim_length_q <= kcg_pkg::AnimLengthRst;
      idle_color_q  <= '0;
      for (int k = 0; k < kcg_pkg::KeyRegs; k++) begin
        key_reg_q[k] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        kcg_pkg::RegNumColors:  num_colors_q <= pwdata[kcg_pkg::NumColorsW-1:0];
        kcg_pkg::RegAnimLength: anim_length_q <= pwdata[kcg_pkg::LenW-1:0];
        kcg_pkg::RegKeyColor0:  if (MAX_COLORS > 0) key_reg_q[0] <= pwdata;
        kcg_pkg::RegKeyColor1:  if (MAX_COLORS > 1) key_reg_q[1] <= pwdata;
        kcg_pkg::RegKeyColor2:  if (MAX_COLORS > 2) key_reg_q[2] <= pwdata;
        kcg_pkg::RegKeyColor3:  if (MAX_COLORS > 3) key_reg_q[3] <= pwdata;
        kcg_pkg::RegIdleColor:  idle_color_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      kcg_pkg::RegNumColors:  prdata = 32'(num_colors_q);
      kcg_pkg::RegAnimLength: prdata = 32'(anim_length_q);
      kcg_pkg::RegKeyColor0:  prdata = key_reg_q[0];
      kcg_pkg::RegKeyColor1:  prdata = key_reg_q[1];
      kcg_pkg::RegKeyColor2:  prdata = key_reg_q[2];
      kcg_pkg::RegKeyColor3:  prdata = key_reg_q[3];
      kcg_pkg::RegIdleColor:  prdata = idle_color_q;
      default:                prdata = '0;
    endcase
  end

  // Keyframe table: registered entries, zero where no register exists
  logic [kcg_pkg::ColorW-1:0] key_colors [MAX_COLORS];
  for (genvar k = 0; k < MAX_COLORS; k++) begin : g_key
    if (k < kcg_pkg::KeyRegs) begin : g_reg
      assign key_colors[k] = key_reg_q[k];
    end else begin : g_zero
      assign key_colors[k] = '0;
    end
  end

  // ---------------------------------------------------------------- effective config
  logic [kcg_pkg::LenW-1:0] len_eff;
  logic [3:0]               ncfg;
  logic [SegW-1:0]          nm1;

  assign len_eff = (anim_length_q == '0) ? kcg_pkg::LenW'(1) : anim_length_q;
  assign ncfg    = {1'b0, num_colors_q};

  // Clamp keyframe count to 2..MAX_COLORS, keep count minus one
  always_comb begin
    if (ncfg < 4'd2) begin
      nm1 = SegW'(1);
    end else if (32'(ncfg) > MAX_COLORS) begin
      nm1 = SegW'(MAX_COLORS - 1);
    end else begin
      nm1 = SegW'(ncfg - 4'd1);
    end
  end

  // ---------------------------------------------------------------- frame counter
  logic [kcg_pkg::LenW-1:0] frame_q;
  logic [kcg_pkg::LenW-1:0] fr_eff;
  logic [kcg_pkg::LenW:0]   fr_inc;
  logic [kcg_pkg::LenW-1:0] frame_d;
  logic                     in_enable;
  logic                     in_acc;

  assign in_enable = s_axis_tdata[0];
  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign fr_eff    = (frame_q >= len_eff) ? '0 : frame_q;
  assign fr_inc    = {1'b0, fr_eff} + 17'd1;

  always_comb begin
    if (!in_enable) begin
      frame_d = '0;
    end else if (fr_inc >= {1'b0, len_eff}) begin
      frame_d = '0;
    end else begin
      frame_d = fr_inc[kcg_pkg::LenW-1:0];
    end
  end

  // Advance or clear the frame as each item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (in_acc) begin
      frame_q <= frame_d;
    end
  end

  // ---------------------------------------------------------------- sequencer
  kcg_pkg::kcg_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      ch_q;
  logic            out_load;
  logic            m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      kcg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = in_enable ? kcg_pkg::ST_MUL : kcg_pkg::ST_DONE;
        end
      end
      kcg_pkg::ST_MUL:   state_d = kcg_pkg::ST_DIV;
      kcg_pkg::ST_DIV:   if (cnt_q == '0) state_d = kcg_pkg::ST_LDSRC;
      kcg_pkg::ST_LDSRC: state_d = kcg_pkg::ST_LDDST;
      kcg_pkg::ST_LDDST: state_d = kcg_pkg::ST_BLEND;
      kcg_pkg::ST_BLEND: if (ch_q == 2'd3) state_d = kcg_pkg::ST_DONE;
      kcg_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = kcg_pkg::ST_IDLE;
        end
      end
      default: state_d = kcg_pkg::ST_IDLE;
    endcase
  end

  // Step counters for the divider and the channel loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ch_q  <= '0;
    end else begin
      case (state_q)
        kcg_pkg::ST_MUL:   cnt_q <= CntW'(NumW - 1);
        kcg_pkg::ST_DIV:   cnt_q <= cnt_q - CntW'(1);
        kcg_pkg::ST_LDDST: ch_q <= '0;
        kcg_pkg::ST_BLEND: ch_q <= ch_q + 2'd1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [kcg_pkg::LenW-1:0]   fr_q;
  logic [NumW-1:0]            num_q;   // dividend in, quotient out
  logic [kcg_pkg::LenW-1:0]   rem_q;
  logic [kcg_pkg::ColorW-1:0] src_q, dst_q, color_q;
  logic [ProdW-1:0]           prod;
  logic [kcg_pkg::LenW:0]     trial;
  logic                       qbit;
  logic [SegW-1:0]            seg;
  logic [kcg_pkg::FracW-1:0]  frac;
  logic [SegW-1:0]            key_addr;
  logic [kcg_pkg::ColorW-1:0] key_rd;

  assign prod  = ProdW'(fr_q) * ProdW'(nm1);
  assign trial = {rem_q, num_q[NumW-1]};
  assign qbit  = (trial >= {1'b0, len_eff});
  assign seg   = num_q[kcg_pkg::FracW +: SegW];
  assign frac  = num_q[kcg_pkg::FracW-1:0];

  // One keyframe read per cycle: segment start, then segment end
  assign key_addr = (state_q == kcg_pkg::ST_LDDST) ? seg + SegW'(1) : seg;
  assign key_rd   = key_colors[key_addr];

  // Blend one channel: src + (dst - src) * frac / 2^16, floored
  logic [4:0]               ch_sh;
  logic [ChW-1:0]           src_ch, dst_ch, res_ch;
  logic signed [ChW:0]      diff;
  logic signed [BlendW-1:0] blend_mul, blend_sum;

  assign ch_sh     = {ch_q, 3'b000};
  assign src_ch    = src_q[ch_sh +: ChW];
  assign dst_ch    = dst_q[ch_sh +: ChW];
  assign diff      = $signed({1'b0, dst_ch}) - $signed({1'b0, src_ch});
  assign blend_mul = BlendW'(diff * $signed({1'b0, frac}));
  assign blend_sum = $signed({2'b00, src_ch, {kcg_pkg::FracW{1'b0}}}) + blend_mul;
  assign res_ch    = blend_sum[kcg_pkg::FracW +: ChW];

  always_ff @(posedge clk_i) begin
    case (state_q)
      kcg_pkg::ST_IDLE: begin
        fr_q    <= fr_eff;
        color_q <= idle_color_q;
      end
      kcg_pkg::ST_MUL: begin
        num_q <= {prod, {kcg_pkg::FracW{1'b0}}};
        rem_q <= '0;
      end
      kcg_pkg::ST_DIV: begin
        // restoring step: shift in a dividend bit, subtract when it fits
        rem_q <= qbit ? kcg_pkg::LenW'(trial - {1'b0, len_eff})
                      : trial[kcg_pkg::LenW-1:0];
        num_q <= {num_q[NumW-2:0], qbit};
      end
      kcg_pkg::ST_LDSRC: src_q <= key_rd;
      kcg_pkg::ST_LDDST: dst_q <= key_rd;
      kcg_pkg::ST_BLEND: color_q[ch_sh +: ChW] <= res_ch;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result register
  logic [kcg_pkg::ColorW-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Reorder to red in the low byte
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= {color_q[7:0], color_q[15:8], color_q[23:16], color_q[31:24]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for keyframe_color_gradient_core, built on kcg_pkg.
// A directed table, then random register settings and random tick bursts; each color is
// checked against the table's want where known is set, else a bit-accurate gradient predictor.

module tb;

  localparam int unsigned MaxColors = 4;
  localparam int unsigned RandTicks = 650;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 60;
  localparam int unsigned DirRows = 43;
  // Decoded by nobody: writes here must leave every setting untouched
  localparam logic [kcg_pkg::RegIdxW-1:0] RegUnused = 3'd7;

  // One color item, red in the low byte as on m_axis_tdata
  typedef struct packed {
    logic [kcg_pkg::ChanW-1:0] alpha;
    logic [kcg_pkg::ChanW-1:0] blue;
    logic [kcg_pkg::ChanW-1:0] green;
    logic [kcg_pkg::ChanW-1:0] red;
  } rgba_beat_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_e;

  // data is the register value for a write, data[0] the enable for a tick;
  // want (RGBA, red on top) is used only where known is set
  typedef struct {
    row_kind_e                   kind;
    logic [kcg_pkg::RegIdxW-1:0] idx;
    logic [kcg_pkg::ColorW-1:0]  data;
    logic                        known;
    logic [kcg_pkg::ColorW-1:0]  want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] enable, [7:1] zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the block's settings and frame counter
  logic [kcg_pkg::NumColorsW-1:0] num_colors_q = kcg_pkg::NumColorsRst;
  logic [kcg_pkg::LenW-1:0]       anim_len_q = kcg_pkg::AnimLengthRst;
  logic [kcg_pkg::ColorW-1:0]     key_q [MaxColors] = '{default: '0};
  logic [kcg_pkg::ColorW-1:0]     idle_q = '0;
  logic [kcg_pkg::LenW-1:0]       frame_q = '0;

  rgba_beat_t colors_due [$];
  int unsigned ticks_sent = 0;
  int unsigned colors_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  string chan_names [4] = '{"red", "green", "blue", "alpha"};

  dir_row_t dir_tbl [DirRows] = '{
    '{ROW_TICK,  '0,                     32'd1,        1'b1, 32'h0000_0000},
    '{ROW_TICK,  '0,                     32'd0,        1'b1, 32'h0000_0000},
    '{ROW_WRITE, kcg_pkg::RegIdleColor,  32'hA1B2C3D4, 1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd0,        1'b1, 32'hA1B2_C3D4},
    '{ROW_WRITE, kcg_pkg::RegKeyColor0,  32'hFFFFFFFF, 1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegKeyColor1,  32'hFFFFFFFF, 1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegAnimLength, 32'd5,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b1, 32'hFFFF_FFFF},
    '{ROW_TICK,  '0,                     32'd1,        1'b1, 32'hFFFF_FFFF},
    '{ROW_WRITE, kcg_pkg::RegKeyColor1,  32'h00000000, 1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegAnimLength, 32'd4,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd0,        1'b1, 32'hA1B2_C3D4},
    '{ROW_TICK,  '0,                     32'd1,        1'b1, 32'hFFFF_FFFF},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    // keyframe count below range, zero length
    '{ROW_WRITE, kcg_pkg::RegNumColors,  32'd0,        1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegAnimLength, 32'd0,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    // keyframe count above range, longest length
    '{ROW_WRITE, kcg_pkg::RegKeyColor2,  32'h12345678, 1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegKeyColor3,  32'h80FF007F, 1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegNumColors,  32'd7,        1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegAnimLength, 32'h0000FFFF, 1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    // shrink the length under the running frame counter
    '{ROW_WRITE, kcg_pkg::RegAnimLength, 32'd2,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegNumColors,  32'd3,        1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegAnimLength, 32'd3,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    // write to an address with no register behind it
    '{ROW_WRITE, RegUnused,              32'hDEADBEEF, 1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegNumColors,  32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_WRITE, kcg_pkg::RegNumColors,  32'd4,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd1,        1'b0, 32'h0},
    '{ROW_TICK,  '0,                     32'd0,        1'b1, 32'hA1B2_C3D4}
  };

  keyframe_color_gradient_core #(
    .MAX_COLORS(MaxColors)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Split an RGBA word (red on top) into an output item
  function automatic rgba_beat_t to_beat(logic [kcg_pkg::ColorW-1:0] c);
    return '{alpha: c[7:0], blue: c[15:8], green: c[23:16], red: c[31:24]};
  endfunction

  // Color of one tick; advances or clears the mirrored frame counter
  function automatic rgba_beat_t gradient_tick(logic en);
    int unsigned len, n, fr, prod, seg, rem, i;
    longint unsigned frac, rem64, mix;
    logic [kcg_pkg::ColorW-1:0] src, dst, c;
    if (!en) begin
      frame_q = '0;
      return to_beat(idle_q);
    end
    len = (anim_len_q == 0) ? 1 : anim_len_q;
    n = num_colors_q;
    if (n < 2) n = 2;
    if (n > MaxColors) n = MaxColors;
    fr = (frame_q >= len) ? 0 : frame_q;
    prod = fr * (n - 1);
    seg = prod / len;
    rem = prod % len;
    rem64 = rem;
    frac = (rem64 << kcg_pkg::FracW) / len;
    if (seg > n - 2) seg = n - 2;
    src = (seg < kcg_pkg::KeyRegs) ? key_q[seg] : '0;
    dst = (seg + 1 < kcg_pkg::KeyRegs) ? key_q[seg + 1] : '0;
    c = '0;
    // blend each byte in 0.16 fixed point and truncate
    for (i = 0; i < 4; i++) begin
      mix = src[8*i +: 8] * (64'd65536 - frac) + dst[8*i +: 8] * frac;
      c[8*i +: 8] = mix[23:16];
    end
    fr = fr + 1;
    if (fr >= len) fr = 0;
    frame_q = fr[kcg_pkg::LenW-1:0];
    return to_beat(c);
  endfunction

  // Offer one tick and hold it until taken, then log its color
  task automatic send_tick(input logic en, input logic known,
                           input logic [kcg_pkg::ColorW-1:0] want);
    rgba_beat_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, en};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = gradient_tick(en);
    colors_due.push_back(known ? to_beat(want) : pred);
    ticks_sent++;
  endtask

  // Stop offering ticks until every color has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk_i);
  endtask

  // Setup and access phase; psel stays up so writes can follow back to back
  task automatic reg_write(input logic [kcg_pkg::RegIdxW-1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      kcg_pkg::RegNumColors:  num_colors_q = val[kcg_pkg::NumColorsW-1:0];
      kcg_pkg::RegAnimLength: anim_len_q = val[kcg_pkg::LenW-1:0];
      kcg_pkg::RegKeyColor0:  key_q[0] = val;
      kcg_pkg::RegKeyColor1:  key_q[1] = val;
      kcg_pkg::RegKeyColor2:  key_q[2] = val;
      kcg_pkg::RegKeyColor3:  key_q[3] = val;
      kcg_pkg::RegIdleColor:  idle_q = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Check each color item, count cycles, and stall the result side
  always @(posedge clk_i) begin : check_colors
    rgba_beat_t want;
    rgba_beat_t got;
    int i;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t ns: run timed out with %0d colors outstanding", $time, colors_due.size());
      $display("FAILURE");
      $finish;
    end else begin
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (colors_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: expected no color, got %h", $time, got);
        end else begin
          want = colors_due.pop_front();
          colors_seen++;
          for (i = 0; i < 4; i++) begin
            if (want[8*i +: 8] !== got[8*i +: 8]) begin
              mismatches++;
              $display("%0t ns: %s expected %02h, got %02h", $time, chan_names[i],
                       want[8*i +: 8], got[8*i +: 8]);
            end
          end
        end
      end
      // long ready stretches, otherwise stall about half the time
      m_axis_tready <= (cycles % 512 < 96) ? 1'b1 : ($urandom_range(0, 99) < 55);
    end
  end

  initial begin : stimulus
    int unsigned r, k, n_ph, burst, phases, rand_sent;
    logic [31:0] val, noise;
    phases = 0;
    rand_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (r = 0; r < DirRows; r++) begin
      if (dir_tbl[r].kind == ROW_WRITE) begin
        drain();
        reg_write(dir_tbl[r].idx, dir_tbl[r].data);
      end else begin
        if (psel) apb_release();
        send_tick(dir_tbl[r].data[0], dir_tbl[r].known, dir_tbl[r].want);
      end
    end
    if (psel) apb_release();

    // Random settings, each followed by a run of bursty ticks
    while (rand_sent < RandTicks) begin
      drain();
      for (r = 0; r < 8; r++) begin
        if (phases == 0 || ($urandom_range(0, 9) < 7 && r != RegUnused) ||
            $urandom_range(0, 9) == 0) begin
          noise = $urandom_range(0, 1) ? $urandom : 32'd0;
          case (r)
            kcg_pkg::RegNumColors: val = {noise[31:3], 3'($urandom_range(0, 7))};
            kcg_pkg::RegAnimLength: begin
              case ($urandom_range(0, 9))
                0: val = 32'd0;
                1: val = 32'd1;
                2: val = 32'h0000_FFFF;
                3: val = $urandom;
                4: val = $urandom_range(2, 3);
                default: val = $urandom_range(4, 24);
              endcase
              val[31:16] = noise[31:16];
            end
            RegUnused: val = $urandom;
            default: begin
              case ($urandom_range(0, 4))
                0: val = 32'h0000_0000;
                1: val = 32'hFFFF_FFFF;
                default: val = $urandom;
              endcase
            end
          endcase
          reg_write(r[kcg_pkg::RegIdxW-1:0], val);
        end
      end
      if (psel) apb_release();

      n_ph = $urandom_range(15, 60);
      burst = $urandom_range(1, 12);
      for (k = 0; k < n_ph && rand_sent < RandTicks; k++) begin
        send_tick($urandom_range(0, 9) != 0, 1'b0, '0);
        rand_sent++;
        burst--;
        if ($urandom_range(0, 39) == 0) begin
          drain();
        end else if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 3) != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 50)) @(posedge clk_i);
          end
        end
      end
      phases++;
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d ticks (%0d random), checked %0d colors", ticks_sent, rand_sent,
             colors_seen);
    $display("Made %0d register writes across %0d random settings", reg_writes, phases);
    if (mismatches == 0 && colors_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
